// ===== rtl/ibmf_pkg.sv =====
`timescale 1ns / 1ps
// Package for the IBM / IEEE single float converter.
// Shared constants, result type and leading-zero count; no dependencies.
package ibmf_pkg;

   localparam int WORD_W = 32;
   localparam int FRAC_W = 24;
   localparam int LZ_W   = 5;
   localparam int EXP_W  = 10;     // signed IEEE exponent before range check

   localparam logic [WORD_W-1:0] MAX_FINITE = 32'h7f7f_ffff;
   localparam logic [EXP_W-1:0]  IBM_BIAS   = 10'd130;
   localparam logic [EXP_W-1:0]  EXP_MAX    = 10'd254;
   localparam logic [7:0]        IBM_EXP_OFFSET = 8'd32;

   localparam logic [1:0] STATUS_NORMAL    = 2'd0;
   localparam logic [1:0] STATUS_OVERFLOW  = 2'd1;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

   localparam logic DIR_IBM_TO_IEEE = 1'b0;
   localparam logic DIR_IEEE_TO_IBM = 1'b1;

   localparam logic REG_DIRECTION = 1'b0;   // word index of the direction register

   typedef struct packed {
      logic [WORD_W-1:0] converted_word;
      logic [1:0]        range_status;
      logic              zero_fraction_flag;
      logic              last_out;
   } result_type;

   // Leading zeros of a nonzero 24-bit fraction.
   function automatic logic [LZ_W-1:0] lead_zeros(input logic [FRAC_W-1:0] frac);
      logic [LZ_W-1:0] count;
      count = '0;
      for (int i = 0; i < FRAC_W; i++) begin
         if (frac[i]) begin
            count = LZ_W'(FRAC_W - 1 - i);
         end
      end
      return count;
   endfunction

endpackage

// ===== rtl/ibmf_pipe.sv =====
`timescale 1ns / 1ps
// Four-stage conversion pipeline: capture, leading-zero count, normalize, range/mux.
// Depends on ibmf_pkg.
module ibmf_pipe (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic                         in_valid,
   input  logic [ibmf_pkg::WORD_W-1:0]  in_word,
   input  logic                         in_last,
   input  logic                         direction,
   output logic                         out_valid,
   output ibmf_pkg::result_type         out_result
);

   // stage 1: capture
   logic                        s1_valid_ff;
   logic [ibmf_pkg::WORD_W-1:0] s1_word_ff;
   logic                        s1_last_ff;
   logic                        s1_dir_ff;

   // stage 2: leading-zero count
   logic                        s2_valid_ff;
   logic [ibmf_pkg::WORD_W-1:0] s2_word_ff;
   logic                        s2_last_ff;
   logic                        s2_dir_ff;
   logic [ibmf_pkg::LZ_W-1:0]   s2_lz_ff;
   logic                        s2_zword_ff;
   logic                        s2_zfrac_ff;

   // stage 3: normalize
   logic                        s3_valid_ff;
   logic                        s3_sign_ff;
   logic                        s3_last_ff;
   logic                        s3_dir_ff;
   logic                        s3_zword_ff;
   logic                        s3_zfrac_ff;
   logic signed [ibmf_pkg::EXP_W-1:0] s3_exp_ff;
   logic [22:0]                 s3_frac_ff;
   logic [ibmf_pkg::WORD_W-1:0] s3_ibm_ff;

   // stage 4: output
   logic                        s4_valid_ff;
   ibmf_pkg::result_type        s4_result_ff;

   logic signed [ibmf_pkg::EXP_W-1:0] s3_exp_in;
   logic [ibmf_pkg::FRAC_W-1:0]       s3_norm_in;
   logic [ibmf_pkg::WORD_W-1:0]       s3_ibm_in;
   logic [8:0]                        ieee_u;
   logic [1:0]                        ieee_sh;
   logic [8:0]                        ieee_ua;
   logic [7:0]                        ibm_exp;
   logic [ibmf_pkg::FRAC_W-1:0]       ieee_frac;
   ibmf_pkg::result_type              s4_result_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_word_ff  <= in_word;
         s1_last_ff  <= in_last;
         s1_dir_ff   <= direction;

         s2_word_ff  <= s1_word_ff;
         s2_last_ff  <= s1_last_ff;
         s2_dir_ff   <= s1_dir_ff;
         s2_lz_ff    <= ibmf_pkg::lead_zeros(s1_word_ff[23:0]);
         s2_zword_ff <= (s1_word_ff == '0);
         s2_zfrac_ff <= (s1_word_ff[23:0] == '0);

         s3_sign_ff  <= s2_word_ff[31];
         s3_last_ff  <= s2_last_ff;
         s3_dir_ff   <= s2_dir_ff;
         s3_zword_ff <= s2_zword_ff;
         s3_zfrac_ff <= s2_zfrac_ff;
         s3_exp_ff   <= s3_exp_in;
         s3_frac_ff  <= s3_norm_in[22:0];
         s3_ibm_ff   <= s3_ibm_in;

         s4_result_ff <= s4_result_in;
      end
   end

   // IBM to IEEE: exponent 4E - 130 - lz, fraction shifted to its top bit
   always_comb begin
      s3_exp_in  = $signed({1'b0, s2_word_ff[30:24], 2'b00})
                   - $signed(ibmf_pkg::IBM_BIAS)
                   - $signed({5'b0, s2_lz_ff});
      s3_norm_in = s2_word_ff[23:0] << s2_lz_ff;
   end

   // IEEE to IBM: align exponent to a multiple of four
   always_comb begin
      ieee_u    = {1'b0, s2_word_ff[30:23]} + 9'd2;
      ieee_sh   = 2'd0 - ieee_u[1:0];
      ieee_ua   = ieee_u + {7'b0, ieee_sh};
      ibm_exp   = {1'b0, ieee_ua[8:2]} + ibmf_pkg::IBM_EXP_OFFSET;
      ieee_frac = {1'b1, s2_word_ff[22:0]} >> ieee_sh;
      if (s2_zword_ff) begin
         s3_ibm_in = '0;
      end else begin
         s3_ibm_in = {s2_word_ff[31], ibm_exp[6:0], ieee_frac};
      end
   end

   always_comb begin
      s4_result_in.last_out           = s3_last_ff;
      s4_result_in.zero_fraction_flag = 1'b0;
      s4_result_in.range_status       = ibmf_pkg::STATUS_NORMAL;
      s4_result_in.converted_word     = '0;
      if (s3_dir_ff == ibmf_pkg::DIR_IEEE_TO_IBM) begin
         s4_result_in.converted_word = s3_ibm_ff;
      end else if (s3_zword_ff) begin
         s4_result_in.converted_word = '0;
      end else if (s3_zfrac_ff) begin
         s4_result_in.zero_fraction_flag = 1'b1;
      end else if (s3_exp_ff > $signed(ibmf_pkg::EXP_MAX)) begin
         s4_result_in.range_status   = ibmf_pkg::STATUS_OVERFLOW;
         s4_result_in.converted_word = {s3_sign_ff, ibmf_pkg::MAX_FINITE[30:0]};
      end else if (s3_exp_ff <= 0) begin
         s4_result_in.range_status   = ibmf_pkg::STATUS_UNDERFLOW;
      end else begin
         s4_result_in.converted_word = {s3_sign_ff, s3_exp_ff[7:0], s3_frac_ff};
      end
   end

   assign out_valid  = s4_valid_ff;
   assign out_result = s4_result_ff;

endmodule

// ===== rtl/ibm_ieee_float_converter_top.sv =====
`timescale 1ns / 1ps
// Top level of the IBM hexadecimal / IEEE 754 single float converter.
// Holds the register port and output handshake; depends on ibmf_pkg and ibmf_pipe.
//
//   channel | ports        | beat contents
//   --------+--------------+------------------------------------------------
//   input   | req_t*       | tdata: sample_word; tlast: last_in
//   result  | rsp_t*       | tdata: converted_word, range_status, zero flag;
//           |              | tlast: last_out
//   control | csr_p*       | word 0: direction (0 IBM->IEEE, 1 IEEE->IBM)
//
// One beat enters per cycle while the result is not stalled; each beat passes
// through the four register stages (capture, leading-zero count, normalize, range check).
// Reset clears the stage valid bits and sets direction to IBM->IEEE.
// A stalled result freezes every stage; nothing is dropped or repeated.
module ibm_ieee_float_converter_top (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,     // [31:0] sample_word
   input  logic        req_tlast,

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,     // [31:0] converted_word, [33:32] range_status,
                                      // [34] zero_fraction_flag, [39:35] zero
   output logic        rsp_tlast,

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic                 direction_ff;
   logic                 advance;
   logic                 pipe_valid;
   ibmf_pkg::result_type pipe_result;

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= ibmf_pkg::DIR_IBM_TO_IEEE;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && csr_paddr[2] == ibmf_pkg::REG_DIRECTION) begin
         direction_ff <= csr_pwdata[0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == ibmf_pkg::REG_DIRECTION) begin
         csr_prdata[0] = direction_ff;
      end
   end

   assign advance    = !pipe_valid || rsp_tready;
   assign req_tready = advance;

   ibmf_pipe u_pipe (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (req_tvalid),
      .in_word    (req_tdata),
      .in_last    (req_tlast),
      .direction  (direction_ff),
      .out_valid  (pipe_valid),
      .out_result (pipe_result)
   );

   assign rsp_tvalid = pipe_valid;
   assign rsp_tdata  = {5'b0, pipe_result.zero_fraction_flag, pipe_result.range_status,
                        pipe_result.converted_word};
   assign rsp_tlast  = pipe_result.last_out;

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[33:32] <= ibmf_pkg::STATUS_UNDERFLOW))
      else $error("range status out of range");

   a_zflag_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[34] |->
         (rsp_tdata[33:32] == ibmf_pkg::STATUS_NORMAL) && (rsp_tdata[31:0] == '0))
      else $error("zero fraction result not clean zero");

   a_overflow_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[33:32] == ibmf_pkg::STATUS_OVERFLOW |->
         rsp_tdata[30:0] == ibmf_pkg::MAX_FINITE[30:0])
      else $error("overflow result not saturated");

   a_underflow_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[33:32] == ibmf_pkg::STATUS_UNDERFLOW |->
         rsp_tdata[31:0] == '0)
      else $error("underflow result not flushed");

endmodule
